>>> rtl/sam_pkg.sv
// shared types and constants of the striped array sector mapper
// depends on nothing; used by the top level and sam_div_step
package sam_pkg;

  localparam int ADDR_BITS  = 48;
  localparam int DIV_STEPS  = 8;
  localparam int DIV_STAGES = ADDR_BITS / DIV_STEPS;
  localparam int REM_W      = 7;

  localparam logic [2:0] OP_WR_ZONE   = 3'd0;
  localparam logic [2:0] OP_WR_MEMBER = 3'd1;
  localparam logic [2:0] OP_WR_DEVOFS = 3'd2;
  localparam logic [2:0] OP_MAP       = 3'd3;
  localparam logic [2:0] OP_MERGE     = 3'd4;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_CANT_SPLIT = 2'd1;
  localparam logic [1:0] ST_NO_ZONE    = 2'd2;

  localparam logic CFG_CHUNK_LOG2   = 1'b0;
  localparam logic CFG_ZONES_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    K_MAP,
    K_ERR,
    K_MERGE
  } kind_e;

  // long division lane: dividend shifts out at the top, quotient shifts in below
  typedef struct packed {
    logic [ADDR_BITS-1:0] x;
    logic [REM_W-1:0]     r;
  } div_lane_t;

endpackage

>>> rtl/striped_array_sector_mapper.sv
// top level of the striped array sector mapper: zone tables, division pipeline
// depends on sam_pkg, sam_ram, sam_div_step
//
// usage
//  - input channel (in_valid_i/in_ready_o) carries one word per request: table
//    writes (zone, member slot, device offset), map requests and merge queries
//  - output channel (out_valid_o/out_ready_i) carries result words; a map
//    request gives one word, or two when it is split at a chunk boundary;
//    last_o marks the final word of a request
//  - config port (cfg_we_i/cfg_index_i/cfg_wdata_i) sets chunk_log2 and
//    zones_in_use, to be written only while the block is idle;
//    the block itself does not enforce this
//  - throughput is one word per cycle while the receiver does not stall; a split
//    request holds the input while its second part is issued; a table write waits
//    until every request in flight has passed the member and device table reads
//  - the device pick needs (block >> chunk_log2) mod members and the chunk
//    number needs a quotient, done as a six stage long division pipeline,
//    eight bits a stage; member and device tables are rams read one after the
//    other, each with a registered read port
//  - when the receiver stalls the whole pipeline holds, and the input is
//    refused only once the output register is full
//  - reset clears valid bits and presets config; tables are undefined until written
module striped_array_sector_mapper
  import sam_pkg::*;
#(
  parameter int MAX_ZONES   = 8,
  parameter int MAX_DEVICES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [2:0]  zone_index_i,
  input  logic [3:0]  slot_index_i,
  input  logic [3:0]  device_id_i,
  input  logic [46:0] zone_start_i,
  input  logic [46:0] zone_blocks_i,
  input  logic [4:0]  member_count_i,
  input  logic [47:0] offset_value_i,
  input  logic [47:0] sector_i,
  input  logic [22:0] request_bytes_i,
  input  logic        single_segment_i,
  input  logic [16:0] vec_bytes_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  target_device_o,
  output logic [47:0] device_sector_o,
  output logic [22:0] part_bytes_o,
  output logic [16:0] merge_bytes_o,
  output logic        last_o
);

  localparam int ZW  = MAX_ZONES > 1 ? $clog2(MAX_ZONES) : 1;
  localparam int DW  = MAX_DEVICES > 1 ? $clog2(MAX_DEVICES) : 1;
  localparam int NBW = $clog2(MAX_DEVICES + 1);
  localparam int MD  = MAX_ZONES * MAX_DEVICES;
  localparam int MW  = MD > 1 ? $clog2(MD) : 1;

  // sideband that travels along with one part
  // sect has one extra top bit: the second part of a split may run past the top
  typedef struct packed {
    logic                 v;
    kind_e                kind;
    logic [1:0]           status;
    logic                 last;
    logic [22:0]          bytes;
    logic [16:0]          merge;
    logic [ADDR_BITS:0]   sect;
    logic [ZW-1:0]        zone;
    logic [ADDR_BITS-1:0] zbase;
    logic [NBW-1:0]       nb;
  } side_t;

  // config registers
  logic [3:0] chunk_log2_q, zones_in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_log2_q   <= 4'd6;
      zones_in_use_q <= 4'd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_CHUNK_LOG2) begin
        chunk_log2_q <= cfg_wdata_i;
      end else begin
        zones_in_use_q <= cfg_wdata_i;
      end
    end
  end

  // pipeline registers
  side_t     p0_q, p0_d, p1_q, m_q, b_q, pend_q, pend_d;
  logic      pend_v_q, pend_v_d;
  logic [46:0] rel_q;
  side_t     sd_q [DIV_STAGES+1];
  div_lane_t lq_q [DIV_STAGES+1];
  div_lane_t lb_q [DIV_STAGES+1];
  div_lane_t lq_n [DIV_STAGES];
  div_lane_t lb_n [DIV_STAGES];
  logic [ADDR_BITS-1:0] a_q, psec_q;
  logic [3:0] dev_b_q;
  logic       dev_ok_q;
  logic       out_valid_q;
  logic [1:0] status_q;
  logic [3:0] tdev_q;
  logic [47:0] dsec_q;
  logic [22:0] pbytes_q;
  logic [16:0] merge_q;
  logic        last_q;

  logic adv, busy, accept, tbl_write, stage_busy;

  assign adv = !out_valid_q || out_ready_i;

  always_comb begin
    stage_busy = p0_q.v || p1_q.v || m_q.v || b_q.v;
    for (int i = 0; i <= DIV_STAGES; i++) begin
      stage_busy = stage_busy || sd_q[i].v;
    end
  end
  assign busy = stage_busy || pend_v_q;

  assign tbl_write = (operation_i == OP_WR_ZONE) || (operation_i == OP_WR_MEMBER) ||
                     (operation_i == OP_WR_DEVOFS);
  assign in_ready_o = adv && !pend_v_q && !(tbl_write && busy);
  assign accept     = in_valid_i && in_ready_o;

  // zone tables in flops, each compared in place
  logic [46:0] zfirst_q [MAX_ZONES];
  logic [46:0] zlen_q   [MAX_ZONES];
  logic [47:0] zbase_q  [MAX_ZONES];
  logic [4:0]  zmc_q    [MAX_ZONES];
  logic [7:0]  zi8, sl8, dv8;

  assign zi8 = 8'(zone_index_i);
  assign sl8 = 8'(slot_index_i);
  assign dv8 = 8'(device_id_i);

  always_ff @(posedge clk_i) begin
    if (accept && operation_i == OP_WR_ZONE && 32'(zone_index_i) < MAX_ZONES) begin
      zfirst_q[zi8[ZW-1:0]] <= zone_start_i;
      zlen_q[zi8[ZW-1:0]]   <= zone_blocks_i;
      zbase_q[zi8[ZW-1:0]]  <= offset_value_i;
      zmc_q[zi8[ZW-1:0]]    <= member_count_i;
    end
  end

  // request front end: split decision and merge answer
  always_comb begin
    logic [16:0] chunk, cs, mxd;
    logic [15:0] off, inch;
    logic [12:0] kb;
    logic [13:0] bs;
    logic [17:0] t;
    logic [25:0] mx;
    logic [16:0] ans;
    logic [22:0] fbytes;
    logic [47:0] fsec;
    chunk  = 17'd1 << chunk_log2_q;
    off    = sector_i[16:1] & 16'(chunk - 17'd1);
    kb     = request_bytes_i[22:10];
    cs     = 17'd2 << chunk_log2_q;
    bs     = request_bytes_i[22:9];
    inch   = sector_i[15:0] & 16'(cs - 17'd1);
    t      = 18'(inch) + 18'(bs);
    mxd    = (18'(cs) > t) ? 17'(18'(cs) - t) : 17'd0;
    mx     = {mxd, 9'd0};
    if (mx <= 26'(vec_bytes_i) && bs == 14'd0) begin
      ans = vec_bytes_i;
    end else begin
      ans = (mx > 26'd65536) ? 17'd65536 : 17'(mx);
    end
    fsec   = 48'(chunk - 17'(off)) << 1;
    fbytes = 23'(fsec << 9);

    p0_d        = '0;
    p0_d.kind   = K_MAP;
    p0_d.sect   = {1'b0, sector_i};
    p0_d.bytes  = request_bytes_i;
    p0_d.last   = 1'b1;
    pend_d      = pend_q;
    pend_v_d    = 1'b0;
    if (pend_v_q) begin
      p0_d = pend_q;
    end else if (accept && operation_i == OP_MAP) begin
      p0_d.v = 1'b1;
      if (chunk < 17'(off) + 17'(kb)) begin
        if (!single_segment_i || 17'(kb) > chunk) begin
          p0_d.kind   = K_ERR;
          p0_d.status = ST_CANT_SPLIT;
        end else begin
          // first part up to the chunk end, second part waits in the pending register
          p0_d.bytes   = fbytes;
          p0_d.last    = 1'b0;
          pend_d       = p0_d;
          pend_d.sect  = {1'b0, sector_i} + {1'b0, fsec};
          pend_d.bytes = request_bytes_i - fbytes;
          pend_d.last  = 1'b1;
          pend_v_d     = 1'b1;
        end
      end
    end else if (accept && operation_i == OP_MERGE) begin
      p0_d.v     = 1'b1;
      p0_d.kind  = K_MERGE;
      p0_d.sect  = '0;
      p0_d.bytes = '0;
      p0_d.merge = ans;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_q.v   <= 1'b0;
      pend_v_q <= 1'b0;
    end else if (adv) begin
      p0_q     <= p0_d;
      pend_v_q <= pend_v_d;
      pend_q   <= pend_d;
    end
  end

  // zone search: first zone holding the block wins
  side_t       p1_d;
  logic [46:0] rel_d;

  always_comb begin
    logic [47:0] block;
    logic [48:0] diff [MAX_ZONES];
    logic [MAX_ZONES-1:0] hit;
    logic        found;
    logic [3:0]  nz;
    nz    = (32'(zones_in_use_q) > MAX_ZONES) ? 4'(MAX_ZONES) : zones_in_use_q;
    block = p0_q.sect[48:1];
    for (int z = 0; z < MAX_ZONES; z++) begin
      diff[z] = {1'b0, block} - {2'b0, zfirst_q[z]};
      hit[z]  = (z < 32'(nz)) && (zmc_q[z] != 5'd0) && !diff[z][48] &&
                (diff[z][47:0] < {1'b0, zlen_q[z]});
    end
    p1_d  = p0_q;
    rel_d = '0;
    found = 1'b0;
    for (int z = MAX_ZONES - 1; z >= 0; z--) begin
      if (hit[z]) begin
        found      = 1'b1;
        p1_d.zone  = ZW'(z);
        p1_d.zbase = zbase_q[z];
        p1_d.nb    = (32'(zmc_q[z]) > MAX_DEVICES) ? NBW'(MAX_DEVICES) : NBW'(zmc_q[z]);
        rel_d      = diff[z][46:0];
      end
    end
    if (p0_q.kind == K_MAP && !found) begin
      p1_d.status = ST_NO_ZONE;
    end
    if (!found) begin
      p1_d.nb = NBW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q.v <= 1'b0;
    end else if (adv) begin
      p1_q  <= p1_d;
      rel_q <= rel_d;
    end
  end

  // chunk shift into the division lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DIV_STAGES; i++) begin
        sd_q[i].v <= 1'b0;
      end
    end else if (adv) begin
      sd_q[0]   <= p1_q;
      lq_q[0].x <= 48'(rel_q >> chunk_log2_q);
      lq_q[0].r <= '0;
      lb_q[0].x <= 48'(p1_q.sect[48:1] >> chunk_log2_q);
      lb_q[0].r <= '0;
      for (int i = 0; i < DIV_STAGES; i++) begin
        sd_q[i+1] <= sd_q[i];
        lq_q[i+1] <= lq_n[i];
        lb_q[i+1] <= lb_n[i];
      end
    end
  end

  // quotient lane gives the chunk number, remainder lane gives the slot
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    sam_div_step u_q (
      .lane_i    (lq_q[g]),
      .divisor_i (REM_W'(sd_q[g].nb)),
      .lane_o    (lq_n[g])
    );
    sam_div_step u_b (
      .lane_i    (lb_q[g]),
      .divisor_i (REM_W'(sd_q[g].nb)),
      .lane_o    (lb_n[g])
    );
  end

  // member table read
  logic [3:0]    mm_rdata;
  logic [MW-1:0] mm_raddr, mm_waddr;
  logic          mm_we;

  assign mm_we    = accept && operation_i == OP_WR_MEMBER &&
                    32'(zone_index_i) < MAX_ZONES && 32'(slot_index_i) < MAX_DEVICES;
  assign mm_waddr = MW'(32'(zi8) * MAX_DEVICES + 32'(sl8));
  assign mm_raddr = MW'(32'(sd_q[DIV_STAGES].zone) * MAX_DEVICES +
                        32'(lb_q[DIV_STAGES].r));

  sam_ram #(
    .WIDTH (4),
    .DEPTH (MD)
  ) u_member_map (
    .clk_i   (clk_i),
    .we_i    (mm_we),
    .waddr_i (mm_waddr),
    .wdata_i (device_id_i),
    .re_i    (adv),
    .raddr_i (mm_raddr),
    .rdata_o (mm_rdata)
  );

  // device offset table read, addressed by the member just read
  logic [47:0]   ddb_rdata;
  logic [7:0]    mdev8;
  logic          ddb_we;
  logic [16:0]   low_mask;

  assign mdev8    = 8'(mm_rdata);
  assign ddb_we   = accept && operation_i == OP_WR_DEVOFS && 32'(device_id_i) < MAX_DEVICES;
  assign low_mask = 17'((18'd2 << chunk_log2_q) - 18'd1);

  sam_ram #(
    .WIDTH (48),
    .DEPTH (MAX_DEVICES)
  ) u_device_base (
    .clk_i   (clk_i),
    .we_i    (ddb_we),
    .waddr_i (dv8[DW-1:0]),
    .wdata_i (offset_value_i),
    .re_i    (adv),
    .raddr_i (mdev8[DW-1:0]),
    .rdata_o (ddb_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q.v <= 1'b0;
      b_q.v <= 1'b0;
    end else if (adv) begin
      m_q      <= sd_q[DIV_STAGES];
      a_q      <= (lq_q[DIV_STAGES].x << chunk_log2_q) + sd_q[DIV_STAGES].zbase;
      b_q      <= m_q;
      psec_q   <= (a_q << 1) + 48'(m_q.sect[16:0] & low_mask);
      dev_b_q  <= mm_rdata;
      dev_ok_q <= 32'(mm_rdata) < MAX_DEVICES;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= b_q.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q <= b_q.status;
      pbytes_q <= b_q.bytes;
      merge_q  <= b_q.merge;
      last_q   <= b_q.last;
      if (b_q.kind == K_MAP && b_q.status == ST_OK) begin
        tdev_q <= dev_b_q;
        dsec_q <= psec_q + (dev_ok_q ? ddb_rdata : 48'd0);
      end else begin
        tdev_q <= 4'd0;
        dsec_q <= 48'd0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign target_device_o = tdev_q;
  assign device_sector_o = dsec_q;
  assign part_bytes_o    = pbytes_q;
  assign merge_bytes_o   = merge_q;
  assign last_o          = last_q;

`ifndef SYNTHESIS
  // table writes never overtake requests still reading the tables
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && tbl_write) |-> !busy)
    else $error("table write while requests in flight");

  // second part of a split blocks the input
  a_split_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> !in_ready_o)
    else $error("input taken while split part pending");

  // a split refusal is a single final word with no target
  a_refuse_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_CANT_SPLIT) |->
      (last_o && target_device_o == 4'd0 && device_sector_o == 48'd0))
    else $error("malformed refusal word");
`endif

endmodule

>>> rtl/sam_ram.sv
// generic simple dual port ram, one write and one registered read port
// depends on nothing
module sam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sam_div_step.sv
// eight restoring long division steps of a lane by a small divisor
// depends on sam_pkg
module sam_div_step
  import sam_pkg::*;
(
  input  div_lane_t        lane_i,
  input  logic [REM_W-1:0] divisor_i,
  output div_lane_t        lane_o
);

  always_comb begin
    logic [ADDR_BITS-1:0] x;
    logic [REM_W:0]       r;
    x = lane_i.x;
    r = {1'b0, lane_i.r};
    for (int i = 0; i < DIV_STEPS; i++) begin
      r = {r[REM_W-1:0], x[ADDR_BITS-1]};
      x = {x[ADDR_BITS-2:0], 1'b0};
      if (r >= {1'b0, divisor_i}) begin
        r    = r - {1'b0, divisor_i};
        x[0] = 1'b1;
      end
    end
    lane_o.x = x;
    lane_o.r = r[REM_W-1:0];
  end

endmodule

>>> tb/striped_array_sector_mapper_test.sv
// testbench for the striped array sector mapper: random and directed words on
// the request channel, each result word checked against a built-in predictor
// depends on sam_pkg and striped_array_sector_mapper
module striped_array_sector_mapper_test;
  import sam_pkg::*;

  localparam int  CYCLE_LIMIT = 600000;
  localparam int  NZ          = 8;
  localparam int  ND          = 16;
  localparam int  HOLD_CYCLES = 80;
  // operation codes 5..7 are not decoded by the block
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [2:0]  zone;
    logic [3:0]  slot;
    logic [3:0]  dev;
    logic [46:0] zstart;
    logic [46:0] zblocks;
    logic [4:0]  members;
    logic [47:0] ofs;
    logic [47:0] sector;
    logic [22:0] bytes;
    logic        single;
    logic [16:0] vec;
  } request_t;

  typedef struct {
    logic [1:0]  status;
    logic [3:0]  dev;
    logic [47:0] dsector;
    logic [22:0] bytes;
    logic [16:0] merge;
    logic        last;
  } result_t;

  // predictor of the mapper plus the queue of result words still owed
  class stripe_scoreboard;
    bit [63:0] chunk_log2, zones_in_use;
    bit [63:0] zfirst[NZ], zlen[NZ], zbase[NZ], zmembers[NZ];
    bit [63:0] member_dev[NZ*ND], dev_base[ND];
    result_t   owed[$];
    int        errors, maps, merges, splits, misses, refused;

    function new();
      chunk_log2   = 6;
      zones_in_use = 1;
    endfunction

    function void set_reg(logic idx, logic [3:0] val);
      if (idx == CFG_CHUNK_LOG2) chunk_log2 = val;
      else zones_in_use = val;
    endfunction

    // map one part that starts at array sector s
    function result_t map_part(bit [63:0] s, bit [63:0] nbytes, bit lst);
      result_t   r;
      bit [63:0] blk, nz, nb, rel, chunk_no, slot, dv, rsect;
      blk = s >> 1;
      nz  = zones_in_use > NZ ? NZ : zones_in_use;
      r = '{ST_NO_ZONE, 4'd0, 48'd0, nbytes[22:0], 17'd0, lst};
      for (int z = 0; z < nz; z++) begin
        nb = zmembers[z] > ND ? ND : zmembers[z];
        if (nb == 0 || blk < zfirst[z]) continue;
        rel = blk - zfirst[z];
        if (rel >= zlen[z]) continue;
        chunk_no = rel / (nb << chunk_log2);
        slot     = (blk >> chunk_log2) % nb;
        dv       = member_dev[z*ND + slot];
        rsect    = (((chunk_no << chunk_log2) + zbase[z]) << 1)
                 + (s & ((64'd2 << chunk_log2) - 1));
        rsect    = rsect + dev_base[dv];
        r = '{ST_OK, dv[3:0], rsect[47:0], nbytes[22:0], 17'd0, lst};
        return r;
      end
      misses++;
      return r;
    endfunction

    function void note_word(request_t w);
      bit [63:0]   chunk, blk, off, kb, fsec, fbytes;
      longint      cs, bs, inch, mx;
      bit [63:0]   ans;
      case (w.op)
        OP_WR_ZONE: begin
          zfirst[w.zone]   = w.zstart;
          zlen[w.zone]     = w.zblocks;
          zmembers[w.zone] = w.members;
          zbase[w.zone]    = w.ofs;
        end
        OP_WR_MEMBER: member_dev[w.zone*ND + w.slot] = w.dev;
        OP_WR_DEVOFS: dev_base[w.dev] = w.ofs;
        OP_MAP: begin
          maps++;
          chunk = 64'd1 << chunk_log2;
          blk   = w.sector >> 1;
          off   = blk & (chunk - 1);
          kb    = w.bytes >> 10;
          if (chunk < off + kb) begin
            if (!w.single || kb > chunk) begin
              refused++;
              owed.push_back('{ST_CANT_SPLIT, 4'd0, 48'd0, w.bytes, 17'd0, 1'b1});
            end else begin
              splits++;
              fsec   = (chunk - off) << 1;
              fbytes = fsec << 9;
              owed.push_back(map_part(w.sector, fbytes, 1'b0));
              owed.push_back(map_part(w.sector + fsec, w.bytes - fbytes, 1'b1));
            end
          end else begin
            owed.push_back(map_part(w.sector, w.bytes, 1'b1));
          end
        end
        OP_MERGE: begin
          merges++;
          cs   = longint'(64'd2 << chunk_log2);
          bs   = longint'(w.bytes >> 9);
          inch = longint'(w.sector & (cs - 1));
          mx   = (cs - (inch + bs)) * 512;
          if (mx < 0) mx = 0;
          if (mx <= w.vec && bs == 0) ans = w.vec;
          else ans = mx > 65536 ? 65536 : mx;
          owed.push_back('{ST_OK, 4'd0, 48'd0, 23'd0, ans[16:0], 1'b1});
        end
        default: ;
      endcase
    endfunction

    function void check_word(result_t got);
      result_t exp_w;
      if (owed.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      exp_w = owed.pop_front();
      if (got.status !== exp_w.status) begin
        $error("status: expected %0d, got %0d", exp_w.status, got.status);
        errors++;
      end
      if (got.dev !== exp_w.dev) begin
        $error("target_device: expected %0d, got %0d", exp_w.dev, got.dev);
        errors++;
      end
      if (got.dsector !== exp_w.dsector) begin
        $error("device_sector: expected %h, got %h", exp_w.dsector, got.dsector);
        errors++;
      end
      if (got.bytes !== exp_w.bytes) begin
        $error("part_bytes: expected %0d, got %0d", exp_w.bytes, got.bytes);
        errors++;
      end
      if (got.merge !== exp_w.merge) begin
        $error("merge_bytes: expected %0d, got %0d", exp_w.merge, got.merge);
        errors++;
      end
      if (got.last !== exp_w.last) begin
        $error("last: expected %0d, got %0d", exp_w.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  request_t    offered;
  result_t     seen;

  stripe_scoreboard sb = new();
  bit        calm = 1'b0;      // last phase: no idling on either side
  bit        hold_now = 1'b0;  // asks the receiver for one long stall
  int        cycles = 0;
  bit [63:0] zs_start[NZ], zs_len[NZ];

  striped_array_sector_mapper uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .operation_i      (offered.op),
    .zone_index_i     (offered.zone),
    .slot_index_i     (offered.slot),
    .device_id_i      (offered.dev),
    .zone_start_i     (offered.zstart),
    .zone_blocks_i    (offered.zblocks),
    .member_count_i   (offered.members),
    .offset_value_i   (offered.ofs),
    .sector_i         (offered.sector),
    .request_bytes_i  (offered.bytes),
    .single_segment_i (offered.single),
    .vec_bytes_i      (offered.vec),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (seen.status),
    .target_device_o  (seen.dev),
    .device_sector_o  (seen.dsector),
    .part_bytes_o     (seen.bytes),
    .merge_bytes_o    (seen.merge),
    .last_o           (seen.last)
  );

  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // handshakes are sampled at the rising edge, before the block updates
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) sb.note_word(offered);
    if (rst_ni && out_valid && out_ready) sb.check_word(seen);
  end

  // receiver: random ready bursts, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_now) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_now = 1'b0;
      end else if (calm) begin
        out_ready = 1'b1;
      end else begin
        out_ready = ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(0, 9)) @(negedge clk_i);
      end
    end
  end

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // every field random so that unused fields still toggle
  function automatic request_t noise_word(logic [2:0] op);
    request_t w;
    w.op = op;
    w.zone = $urandom;
    w.slot = $urandom;
    w.dev = $urandom;
    w.zstart = rand64();
    w.zblocks = rand64();
    w.members = $urandom;
    w.ofs = rand64();
    w.sector = rand64();
    w.bytes = $urandom_range(0, 4194304);
    w.single = $urandom;
    w.vec = $urandom_range(0, 65536);
    return w;
  endfunction

  task automatic send_word(request_t w);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    offered  = w;
    in_valid = 1'b1;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  // wait until every owed word is back, then let the pipeline drain
  task automatic wait_idle();
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [3:0] val);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  // lay out all eight zones, mostly back to back so map requests hit
  task automatic build_zones(int cl);
    request_t  w;
    bit [63:0] cursor;
    case ($urandom_range(0, 2))
      0: cursor = 0;
      1: cursor = $urandom;
      default: cursor = (64'd1 << 47) - (64'd1 << 22);  // near the top block
    endcase
    for (int z = 0; z < NZ; z++) begin
      w = noise_word(OP_WR_ZONE);
      w.zone = z;
      zs_start[z] = cursor[46:0];
      zs_len[z] = ($urandom_range(0, 15) == 0) ? 0 :
                  (64'($urandom_range(1, 40)) << cl) + $urandom_range(0, 700);
      w.zstart  = zs_start[z];
      w.zblocks = zs_len[z];
      // a few zones with no members or too many
      w.members = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      if ($urandom_range(0, 5) != 0) cursor = cursor + zs_len[z];  // else overlap
      send_word(w);
    end
  endtask

  function automatic request_t map_word();
    request_t w;
    int       z;
    w = noise_word(OP_MAP);
    z = $urandom_range(0, NZ - 1);
    if ($urandom_range(0, 9) != 0)
      w.sector = ((zs_start[z] + rand64() % (zs_len[z] + 8)) << 1) | $urandom_range(0, 1);
    case ($urandom_range(0, 5))
      0: w.bytes = $urandom_range(0, 1023);
      1: w.bytes = 4194304;
      default: w.bytes = $urandom_range(0, 4096) * 1024 + $urandom_range(0, 1023);
    endcase
    if (w.bytes > 4194304) w.bytes = 4194304;
    w.single = ($urandom_range(0, 4) != 0);
    return w;
  endfunction

  function automatic request_t random_word();
    request_t w;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) w = map_word();
    else if (pick < 85) begin
      w = noise_word(OP_MERGE);
      w.bytes = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 8191) : w.bytes;
      w.vec = ($urandom_range(0, 3) == 0) ? 17'd65536 : w.vec;
    end else if (pick < 91) w = noise_word(OP_WR_MEMBER);
    else if (pick < 96) w = noise_word(OP_WR_DEVOFS);
    else w = noise_word($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    return w;
  endfunction

  initial begin
    int       cl_set[7] = '{2, 12, 0, 15, 6, 9, 4};
    int       zu_set[7] = '{1, 8, 15, 0, 3, 8, 5};
    request_t w;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // every table entry gets written before any lookup can touch it
    build_zones(6);
    for (int i = 0; i < NZ * ND; i++) begin
      w = noise_word(OP_WR_MEMBER);
      w.zone = i / ND;
      w.slot = i % ND;
      send_word(w);
    end
    for (int d = 0; d < ND; d++) begin
      w = noise_word(OP_WR_DEVOFS);
      w.dev = d;
      send_word(w);
    end

    for (int p = 0; p < 7; p++) begin
      drop_valid();
      wait_idle();  // sender pauses until the block is empty
      write_reg(CFG_CHUNK_LOG2, cl_set[p]);
      write_reg(CFG_ZONES_IN_USE, zu_set[p]);
      if (p == 6) calm = 1'b1;
      build_zones(cl_set[p]);

      if (p == 0) begin
        // directed corners: sizes, chunk crossings, top addresses, idle codes
        w = noise_word(OP_WR_MEMBER);
        w.zone = 7; w.slot = 15; w.dev = 15;
        send_word(w);
        w = noise_word(OP_WR_DEVOFS);
        w.dev = 15; w.ofs = '1;
        send_word(w);
        w = map_word(); w.sector = zs_start[0] << 1; w.bytes = 0;
        send_word(w);
        w = map_word(); w.sector = ((zs_start[0] + 3) << 1) | 1; w.bytes = 2048;
        w.single = 1;
        send_word(w);  // crosses into the next chunk when zone 0 starts chunk aligned, split in two
        w.single = 0;
        send_word(w);  // same crossing, not single segment
        w = map_word(); w.bytes = 4194304; w.single = 1;
        send_word(w);  // longer than one chunk
        w = map_word(); w.sector = '1;
        send_word(w);
        w = map_word(); w.sector = '0; w.bytes = 0;
        send_word(w);
        w = noise_word(OP_MERGE); w.sector = 0; w.bytes = 0; w.vec = 0;
        send_word(w);
        w.vec = 65536;
        send_word(w);
        w.bytes = 4194304; w.sector = '1;
        send_word(w);
        w.bytes = 511; w.vec = 100;
        send_word(w);
        for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
          send_word(noise_word(op));
      end

      if (p == 1) hold_now = 1'b1;  // long receiver stall while words keep coming
      for (int i = 0; i < 105; i++) send_word(random_word());
    end

    drop_valid();
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.owed.size() != 0) sb.errors++;

    $display("covered %0d map requests (%0d split, %0d refused, %0d unmapped parts)",
             sb.maps, sb.splits, sb.refused, sb.misses);
    $display("and %0d merge queries over 7 chunk and zone settings", sb.merges);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
